/* design/tnmp_pkg.sv */
// Shared constants and types for the three-node meeting point core.
package tnmp_pkg;

	// Field widths
	localparam int NODE_W  = 10;
	localparam int DEPTH_W = 10;
	localparam int DIST_W  = 12;
	localparam int LVL_W   = 4;

	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	// Parameter defaults
	localparam int MAX_NODES_DEF   = 1024;
	localparam int JUMP_LEVELS_DEF = 10;

	// Transaction kinds
	localparam logic KIND_LOAD  = 1'b0;
	localparam logic KIND_QUERY = 1'b1;

	// Memory access request from the sequencer
	typedef struct packed {
		logic [NODE_W-1:0]  anc_node;
		logic [LVL_W-1:0]   anc_lvl;
		logic [NODE_W-1:0]  dep_node;
		logic               anc_we;
		logic               dep_we;
		logic [NODE_W-1:0]  wnode;
		logic [LVL_W-1:0]   wlvl;
		logic [NODE_W-1:0]  anc_wdata;
		logic [DEPTH_W-1:0] dep_wdata;
	} mem_req_t;

endpackage

/* design/tnmp_mem.sv */
// Ancestor jump table and depth memories, registered reads.
module tnmp_mem #(
	parameter int MAX_NODES   = tnmp_pkg::MAX_NODES_DEF,
	parameter int JUMP_LEVELS = tnmp_pkg::JUMP_LEVELS_DEF
) (
	input  logic                           clk,
	input  tnmp_pkg::mem_req_t             req,
	output logic [tnmp_pkg::NODE_W-1:0]    anc_rdata,
	output logic [tnmp_pkg::DEPTH_W-1:0]   dep_rdata
);

	localparam int AW        = $clog2(MAX_NODES);
	localparam int LW        = (JUMP_LEVELS > 1) ? $clog2(JUMP_LEVELS) : 1;
	localparam int NODE_WORDS = 2 ** AW;
	localparam int ANC_WORDS  = NODE_WORDS * (2 ** LW);

	logic [tnmp_pkg::NODE_W-1:0]  anc_mem [0:ANC_WORDS-1];
	logic [tnmp_pkg::DEPTH_W-1:0] dep_mem [0:NODE_WORDS-1];

	logic [tnmp_pkg::NODE_W-1:0]  anc_rd_q;
	logic [tnmp_pkg::DEPTH_W-1:0] dep_rd_q;
	logic                         anc_zero_q;
	logic                         dep_zero_q;

	logic [AW+LW-1:0] anc_raddr;
	logic [AW+LW-1:0] anc_waddr;
	logic [AW-1:0]    dep_raddr;
	logic [AW-1:0]    dep_waddr;

	// Nodes past the table read as zero and are never written
	function automatic logic in_range(input logic [tnmp_pkg::NODE_W-1:0] n);
		return (17'(n) < 17'(MAX_NODES));
	endfunction

	assign anc_raddr = {AW'(req.anc_node), req.anc_lvl[LW-1:0]};
	assign anc_waddr = {AW'(req.wnode), req.wlvl[LW-1:0]};
	assign dep_raddr = AW'(req.dep_node);
	assign dep_waddr = AW'(req.wnode);

	// Jump table
	always_ff @(posedge clk) begin
		if (req.anc_we && in_range(req.wnode)) begin
			anc_mem[anc_waddr] <= req.anc_wdata;
		end
		anc_rd_q   <= anc_mem[anc_raddr];
		anc_zero_q <= (req.anc_node == '0) || !in_range(req.anc_node);
	end

	// Depths
	always_ff @(posedge clk) begin
		if (req.dep_we && in_range(req.wnode)) begin
			dep_mem[dep_waddr] <= req.dep_wdata;
		end
		dep_rd_q   <= dep_mem[dep_raddr];
		dep_zero_q <= (req.dep_node == '0) || !in_range(req.dep_node);
	end

	// Node zero is the sentinel: all its entries read as zero
	assign anc_rdata = anc_zero_q ? '0 : anc_rd_q;
	assign dep_rdata = dep_zero_q ? '0 : dep_rd_q;

endmodule

/* design/tree_three_node_meeting_point_core.sv */
// Top level: binary-lifting common ancestor core with a three-node meeting query.
// A load writes the depth and the level-0 ancestor, then one jump-table read and write per higher level.
// A query reads the three depths, then per pair lifts the deeper node and climbs both nodes
// level by level; these steps are serialized by the single read port of the jump table.
// One transaction at a time; a finished result waits in an output register.
// arst_n clears the sequencer and the output valid; memory contents are not cleared.
module tree_three_node_meeting_point_core #(
	parameter int MAX_NODES   = tnmp_pkg::MAX_NODES_DEF,
	parameter int JUMP_LEVELS = tnmp_pkg::JUMP_LEVELS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          kind,
	input  logic [tnmp_pkg::NODE_W-1:0]   node_a,
	input  logic [tnmp_pkg::NODE_W-1:0]   node_b,
	input  logic [tnmp_pkg::NODE_W-1:0]   node_c,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tnmp_pkg::NODE_W-1:0]   meeting_node,
	output logic [tnmp_pkg::DIST_W-1:0]   total_distance
);

	localparam int KW = $clog2(JUMP_LEVELS + 1);
	localparam logic [KW-1:0] K_LAST = KW'(JUMP_LEVELS);

	// Sequencer states
	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_LD_D    = 5'd1;
	localparam logic [4:0] ST_LD_R    = 5'd2;
	localparam logic [4:0] ST_LD_W    = 5'd3;
	localparam logic [4:0] ST_Q_DA    = 5'd4;
	localparam logic [4:0] ST_Q_DB    = 5'd5;
	localparam logic [4:0] ST_Q_DC    = 5'd6;
	localparam logic [4:0] ST_L_INIT  = 5'd7;
	localparam logic [4:0] ST_LIFT    = 5'd8;
	localparam logic [4:0] ST_LIFT_W  = 5'd9;
	localparam logic [4:0] ST_UP_X    = 5'd10;
	localparam logic [4:0] ST_UP_Y    = 5'd11;
	localparam logic [4:0] ST_UP_C    = 5'd12;
	localparam logic [4:0] ST_FIN_W   = 5'd13;
	localparam logic [4:0] ST_ANC_DEP = 5'd14;
	localparam logic [4:0] ST_ANC_DW  = 5'd15;
	localparam logic [4:0] ST_OUT     = 5'd16;

	localparam logic [1:0] PAIR_LAST = 2'd2;

	logic [4:0]    state_q;
	logic [KW-1:0] k_q;
	logic [1:0]    pair_q;
	logic          out_valid_q;

	logic [tnmp_pkg::NODE_W-1:0]  a_q, b_q, c_q;
	logic [tnmp_pkg::DEPTH_W-1:0] da_q, db_q, dc_q;
	logic [tnmp_pkg::NODE_W-1:0]  x_q, y_q, px_q, anc_q, cur_q, meet_q;
	logic [tnmp_pkg::DEPTH_W-1:0] diff_q;
	logic [tnmp_pkg::DIST_W-1:0]  dist_q;
	logic [tnmp_pkg::NODE_W-1:0]  out_meet_q;
	logic [tnmp_pkg::DIST_W-1:0]  out_dist_q;

	tnmp_pkg::mem_req_t           req;
	logic [tnmp_pkg::NODE_W-1:0]  anc_rdata;
	logic [tnmp_pkg::DEPTH_W-1:0] dep_rdata;

	logic                         in_fire;
	logic                         out_load;
	logic [KW-1:0]                k_dec;
	logic [tnmp_pkg::NODE_W-1:0]  sx, sy;
	logic [tnmp_pkg::DEPTH_W-1:0] sdx, sdy;
	logic                         swap;
	logic [tnmp_pkg::DEPTH_W-1:0] dep_inc;

	assign in_ready  = (state_q == ST_IDLE);
	assign in_fire   = in_valid && in_ready;
	assign out_load  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	assign k_dec     = k_q - KW'(1);
	assign dep_inc   = (dep_rdata == tnmp_pkg::DEPTH_MAX) ? dep_rdata : dep_rdata + 1'b1;

	// Pair selection: (a,b), (b,c), (c,a); deeper node goes to x
	always_comb begin
		case (pair_q)
			2'd0: begin
				sx = a_q; sy = b_q; sdx = da_q; sdy = db_q;
			end
			2'd1: begin
				sx = b_q; sy = c_q; sdx = db_q; sdy = dc_q;
			end
			default: begin
				sx = c_q; sy = a_q; sdx = dc_q; sdy = da_q;
			end
		endcase
		swap = (sdx < sdy);
	end

	// Memory request per state
	always_comb begin
		req = '0;
		req.wnode = a_q;
		case (state_q)
			ST_IDLE: begin
				req.dep_node = (kind == tnmp_pkg::KIND_QUERY) ? node_a : node_b;
			end
			ST_LD_D: begin
				req.dep_we    = 1'b1;
				req.dep_wdata = dep_inc;
				req.anc_we    = 1'b1;
				req.wlvl      = '0;
				req.anc_wdata = b_q;
			end
			ST_LD_R: begin
				req.anc_node = cur_q;
				req.anc_lvl  = tnmp_pkg::LVL_W'(k_dec);
			end
			ST_LD_W: begin
				req.anc_we    = 1'b1;
				req.wlvl      = tnmp_pkg::LVL_W'(k_q);
				req.anc_wdata = anc_rdata;
			end
			ST_Q_DA: begin
				req.dep_node = b_q;
			end
			ST_Q_DB: begin
				req.dep_node = c_q;
			end
			ST_LIFT: begin
				req.anc_node = x_q;
				req.anc_lvl  = tnmp_pkg::LVL_W'(k_q);
			end
			ST_UP_X: begin
				req.anc_node = x_q;
				req.anc_lvl  = (k_q == '0) ? '0 : tnmp_pkg::LVL_W'(k_dec);
			end
			ST_UP_Y: begin
				req.anc_node = y_q;
				req.anc_lvl  = tnmp_pkg::LVL_W'(k_dec);
			end
			ST_ANC_DEP: begin
				req.dep_node = anc_q;
			end
			default: begin
				req.dep_node = '0;
			end
		endcase
	end

	tnmp_mem #(
		.MAX_NODES   (MAX_NODES),
		.JUMP_LEVELS (JUMP_LEVELS)
	) u_mem (
		.clk       (clk),
		.req       (req),
		.anc_rdata (anc_rdata),
		.dep_rdata (dep_rdata)
	);

	// Sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			k_q     <= '0;
			pair_q  <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						if (kind == tnmp_pkg::KIND_QUERY) begin
							state_q <= ST_Q_DA;
						end else if (node_a != '0) begin
							state_q <= ST_LD_D;
						end
					end
				end
				ST_LD_D: begin
					k_q     <= KW'(1);
					state_q <= ST_LD_R;
				end
				ST_LD_R: begin
					state_q <= (k_q == K_LAST) ? ST_IDLE : ST_LD_W;
				end
				ST_LD_W: begin
					k_q     <= k_q + KW'(1);
					state_q <= ST_LD_R;
				end
				ST_Q_DA: state_q <= ST_Q_DB;
				ST_Q_DB: state_q <= ST_Q_DC;
				ST_Q_DC: begin
					pair_q  <= '0;
					state_q <= ST_L_INIT;
				end
				ST_L_INIT: begin
					k_q     <= '0;
					state_q <= ST_LIFT;
				end
				ST_LIFT: begin
					if (k_q == K_LAST) begin
						state_q <= (x_q == y_q) ? ST_ANC_DEP : ST_UP_X;
					end else if (diff_q[0]) begin
						state_q <= ST_LIFT_W;
					end else begin
						k_q <= k_q + KW'(1);
					end
				end
				ST_LIFT_W: begin
					k_q     <= k_q + KW'(1);
					state_q <= ST_LIFT;
				end
				ST_UP_X: begin
					state_q <= (k_q == '0) ? ST_FIN_W : ST_UP_Y;
				end
				ST_UP_Y: state_q <= ST_UP_C;
				ST_UP_C: begin
					k_q     <= k_dec;
					state_q <= ST_UP_X;
				end
				ST_FIN_W:   state_q <= ST_ANC_DEP;
				ST_ANC_DEP: state_q <= ST_ANC_DW;
				ST_ANC_DW: begin
					if (pair_q == PAIR_LAST) begin
						state_q <= ST_OUT;
					end else begin
						pair_q  <= pair_q + 2'd1;
						state_q <= ST_L_INIT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire) begin
					a_q <= node_a;
					b_q <= node_b;
					c_q <= node_c;
				end
			end
			ST_LD_D: cur_q <= b_q;
			ST_LD_W: cur_q <= anc_rdata;
			ST_Q_DA: da_q <= dep_rdata;
			ST_Q_DB: db_q <= dep_rdata;
			ST_Q_DC: begin
				dc_q   <= dep_rdata;
				dist_q <= tnmp_pkg::DIST_W'(da_q) + tnmp_pkg::DIST_W'(db_q)
					+ tnmp_pkg::DIST_W'(dep_rdata);
				meet_q <= '0;
			end
			ST_L_INIT: begin
				x_q    <= swap ? sy : sx;
				y_q    <= swap ? sx : sy;
				diff_q <= swap ? (sdy - sdx) : (sdx - sdy);
			end
			ST_LIFT: begin
				if (k_q == K_LAST) begin
					anc_q <= x_q;
				end else if (!diff_q[0]) begin
					diff_q <= diff_q >> 1;
				end
			end
			ST_LIFT_W: begin
				x_q    <= anc_rdata;
				diff_q <= diff_q >> 1;
			end
			ST_UP_Y: px_q <= anc_rdata;
			ST_UP_C: begin
				if (anc_rdata != px_q) begin
					x_q <= px_q;
					y_q <= anc_rdata;
				end
			end
			ST_FIN_W:   anc_q  <= anc_rdata;
			ST_ANC_DEP: meet_q <= meet_q ^ anc_q;
			ST_ANC_DW:  dist_q <= dist_q - tnmp_pkg::DIST_W'(dep_rdata);
			default: begin
				cur_q <= cur_q;
			end
		endcase
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_meet_q <= meet_q;
			out_dist_q <= dist_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign meeting_node   = out_meet_q;
	assign total_distance = out_dist_q;

	// Checks
	a_k_bound: assert property (@(posedge clk) disable iff (!arst_n)
		k_q <= K_LAST)
		else $error("level counter past the jump table");

	a_pair_bound: assert property (@(posedge clk) disable iff (!arst_n)
		pair_q <= PAIR_LAST)
		else $error("pair index out of range");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && kind == tnmp_pkg::KIND_QUERY) |=> state_q == ST_Q_DA)
		else $error("query transaction did not start the depth reads");

	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_OUT && out_valid_q && !out_ready) |=> state_q == ST_OUT)
		else $error("result overwritten while the previous one waits");

endmodule
